// ----- sv/modbus_rtu_response_checker_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Modbus RTU response checker assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst_n low.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_RESPONSE_CHECKER_UNIT_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define MRRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MRRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mrrc_pkg.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU response checker package
// Codes, field widths and the CRC-16 byte update shared by the block's files.
// ----------------------------------------------------------------------------
package mrrc_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [2:0] status_t;

  localparam kind_t KIND_NONE  = 2'd0;
  localparam kind_t KIND_READ  = 2'd1;
  localparam kind_t KIND_WRITE = 2'd2;

  localparam status_t ST_OK           = 3'd0;
  localparam status_t ST_NOT_AWAITED  = 3'd1;
  localparam status_t ST_ADDR_MISMATCH = 3'd2;
  localparam status_t ST_FUNC_MISMATCH = 3'd3;
  localparam status_t ST_CRC_MISMATCH = 3'd4;
  localparam status_t ST_TOO_SHORT    = 3'd5;

  localparam logic RK_WORD   = 1'b0;
  localparam logic RK_STATUS = 1'b1;

  localparam logic CFG_SLAVE_ADDRESS = 1'b0;
  localparam logic CFG_EXPECTED_KIND = 1'b1;

  localparam int POS_W = 9;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  WRITE_FUNCTION = 8'd16;
  localparam logic [POS_W-1:0] WRITE_COVER = 9'd6;
  localparam logic [7:0]  ADDR_RESET = 8'd2;

  // One byte of reflected CRC-16, eight shift/xor steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/mrrc_if.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU response checker channels
// Valid/ready channel for received bytes and for checker results.
// ----------------------------------------------------------------------------
interface mrrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrrc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] word_value;
  logic [6:0]  word_index;
  logic [2:0]  frame_status;

  modport source (output valid, output result_kind, output word_value,
                  output word_index, output frame_status, input ready);
  modport sink   (input valid, input result_kind, input word_value,
                  input word_index, input frame_status, output ready);
endinterface

// ----- sv/modbus_rtu_response_checker_unit.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU response checker
// Byte-wise frame check with running CRC-16 and register word extraction.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one received UART byte per transfer, or an end marker
//   (frame_end high) when the line has gone idle; rx_byte is ignored then.
//   out_ch carries at most one result per input transfer: a register word
//   (read mode, once both bytes of a word are in) or a frame status at the
//   end marker. Words are only trustworthy if their frame's status is ok.
//   cfg_we/cfg_index/cfg_wdata set the slave address and the awaited kind;
//   write them only while no frame is in flight and the output is drained.
// Timing:
//   A result appears on out_ch the cycle after the input transfer that causes
//   it, through the result register. One byte is taken per cycle while the
//   output is not stalled: the CRC update is an eight-step xor network on one byte.
// Reset (rst_n low, synchronous): frame state cleared, CRC to 0xFFFF, slave
//   address 2, nothing awaited, output empty.
// Stall: while a result waits in the result register and out_ch.ready is low,
//   in_ch.ready drops; bytes that produce no result are still held back.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_unit (
  input  logic       clk,
  input  logic       rst_n,
  mrrc_in_if.sink    in_ch,
  mrrc_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  // Configuration
  logic [7:0]      slave_addr_r;
  mrrc_pkg::kind_t kind_r;

  // Frame state
  logic [mrrc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] rx_crc_r, rx_crc_nxt;
  logic [1:0]  flags_r, flags_nxt;   // bit0 address mismatch, bit1 function mismatch

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [15:0] out_word_r, out_word_nxt;
  logic [6:0]  out_idx_r, out_idx_nxt;
  logic [2:0]  out_status_r, out_status_nxt;

  logic accept;
  logic emit;
  logic [mrrc_pkg::POS_W-1:0] cnt3;
  logic [mrrc_pkg::POS_W-1:0] cnt5;
  logic [mrrc_pkg::POS_W-1:0] pos_m4;
  logic [15:0] crc_upd;
  mrrc_pkg::status_t status;

  // Accept a new byte whenever the result register is free or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign cnt3    = {1'b0, count_r} + 9'd3;
  assign cnt5    = {1'b0, count_r} + 9'd5;
  assign pos_m4  = pos_r - 9'd4;
  assign crc_upd = mrrc_pkg::crc_byte(crc_r, in_ch.rx_byte);

  // Frame status at the end marker, in priority order.
  always_comb begin
    status = mrrc_pkg::ST_OK;
    if (kind_r != mrrc_pkg::KIND_READ && kind_r != mrrc_pkg::KIND_WRITE) begin
      status = mrrc_pkg::ST_NOT_AWAITED;
    end else if (pos_r == '0) begin
      status = mrrc_pkg::ST_TOO_SHORT;
    end else if (flags_r[0]) begin
      status = mrrc_pkg::ST_ADDR_MISMATCH;
    end else if (kind_r == mrrc_pkg::KIND_WRITE) begin
      if (pos_r < 9'd2) begin
        status = mrrc_pkg::ST_TOO_SHORT;
      end else if (flags_r[1]) begin
        status = mrrc_pkg::ST_FUNC_MISMATCH;
      end else if (pos_r < mrrc_pkg::WRITE_COVER + 9'd2) begin
        status = mrrc_pkg::ST_TOO_SHORT;
      end else if (crc_r != rx_crc_r) begin
        status = mrrc_pkg::ST_CRC_MISMATCH;
      end
    end else begin
      if (pos_r < 9'd3 || pos_r < cnt5) begin
        status = mrrc_pkg::ST_TOO_SHORT;
      end else if (crc_r != rx_crc_r) begin
        status = mrrc_pkg::ST_CRC_MISMATCH;
      end
    end
  end

  // Per-byte frame update and result formation.
  always_comb begin
    pos_nxt        = pos_r;
    crc_nxt        = crc_r;
    count_nxt      = count_r;
    hold_nxt       = hold_r;
    rx_crc_nxt     = rx_crc_r;
    flags_nxt      = flags_r;
    emit           = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_word_nxt   = out_word_r;
    out_idx_nxt    = out_idx_r;
    out_status_nxt = out_status_r;

    if (accept) begin
      if (in_ch.frame_end) begin
        emit           = 1'b1;
        out_kind_nxt   = mrrc_pkg::RK_STATUS;
        out_word_nxt   = '0;
        out_idx_nxt    = '0;
        out_status_nxt = status;
        // Restart the frame.
        pos_nxt    = '0;
        crc_nxt    = mrrc_pkg::CRC_INIT;
        count_nxt  = '0;
        hold_nxt   = '0;
        rx_crc_nxt = '0;
        flags_nxt  = '0;
      end else begin
        if ((kind_r == mrrc_pkg::KIND_READ || kind_r == mrrc_pkg::KIND_WRITE)
            && pos_r == '0 && in_ch.rx_byte != slave_addr_r) begin
          flags_nxt[0] = 1'b1;
        end

        if (kind_r == mrrc_pkg::KIND_READ) begin
          if (pos_r == 9'd2) begin
            count_nxt = in_ch.rx_byte;
          end
          if (pos_r < 9'd3 || pos_r < cnt3) begin
            crc_nxt = crc_upd;
            if (pos_r >= 9'd3) begin
              if (pos_r[0]) begin
                // First byte of a word: hold it.
                hold_nxt = in_ch.rx_byte;
              end else begin
                emit           = 1'b1;
                out_kind_nxt   = mrrc_pkg::RK_WORD;
                out_word_nxt   = {hold_r, in_ch.rx_byte};
                out_idx_nxt    = pos_m4[7:1];
                out_status_nxt = mrrc_pkg::ST_OK;
              end
            end
          end else if (pos_r == cnt3) begin
            rx_crc_nxt[7:0] = in_ch.rx_byte;
          end else if (pos_r == cnt3 + 9'd1) begin
            rx_crc_nxt[15:8] = in_ch.rx_byte;
          end
        end else if (kind_r == mrrc_pkg::KIND_WRITE) begin
          if (pos_r == 9'd1 && in_ch.rx_byte != mrrc_pkg::WRITE_FUNCTION) begin
            flags_nxt[1] = 1'b1;
          end
          if (pos_r < mrrc_pkg::WRITE_COVER) begin
            crc_nxt = crc_upd;
          end else if (pos_r == mrrc_pkg::WRITE_COVER) begin
            rx_crc_nxt[7:0] = in_ch.rx_byte;
          end else if (pos_r == mrrc_pkg::WRITE_COVER + 9'd1) begin
            rx_crc_nxt[15:8] = in_ch.rx_byte;
          end
        end

        // Advance the position, saturating.
        if (pos_r != mrrc_pkg::POS_MAX) begin
          pos_nxt = pos_r + 9'd1;
        end
      end
    end

    out_valid_nxt = (out_valid_r && !out_ch.ready) || emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= mrrc_pkg::ADDR_RESET;
      kind_r       <= mrrc_pkg::KIND_NONE;
      pos_r        <= '0;
      crc_r        <= mrrc_pkg::CRC_INIT;
      count_r      <= '0;
      hold_r       <= '0;
      rx_crc_r     <= '0;
      flags_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mrrc_pkg::CFG_SLAVE_ADDRESS: slave_addr_r <= cfg_wdata;
          mrrc_pkg::CFG_EXPECTED_KIND: kind_r       <= cfg_wdata[1:0];
          default: ;
        endcase
      end
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      count_r     <= count_nxt;
      hold_r      <= hold_nxt;
      rx_crc_r    <= rx_crc_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload of the result register: load on emit, hold otherwise.
  always_ff @(posedge clk) begin
    out_kind_r   <= out_kind_nxt;
    out_word_r   <= out_word_nxt;
    out_idx_r    <= out_idx_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_kind_r;
  assign out_ch.word_value   = out_word_r;
  assign out_ch.word_index   = out_idx_r;
  assign out_ch.frame_status = out_status_r;

endmodule

// ----- sv/mrrc_checker.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU response checker port assertions
// Checks result formatting and the stall behavior seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "modbus_rtu_response_checker_unit_defines.svh"

module mrrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_frame_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_result_kind,
  input logic [15:0] out_word_value,
  input logic [6:0]  out_word_index,
  input logic [2:0]  out_frame_status
);

  `MRRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_result_kind) && $stable(out_word_value) && $stable(out_word_index) && $stable(out_frame_status), "stalled result changed")
  `MRRC_ASSERT_NOW(a_status_clean, out_valid && out_result_kind == mrrc_pkg::RK_STATUS, out_word_value == '0 && out_word_index == '0, "status result carries word fields")
  `MRRC_ASSERT_NOW(a_word_clean, out_valid && out_result_kind == mrrc_pkg::RK_WORD, out_frame_status == mrrc_pkg::ST_OK, "word result carries a status")
  `MRRC_ASSERT_NEXT(a_end_status, in_valid && in_ready && in_frame_end, out_valid && out_result_kind == mrrc_pkg::RK_STATUS, "end marker gave no status")
  `MRRC_ASSERT_NOW(a_ready_stall, !in_ready, out_valid && !out_ready, "input held back without a stalled result")

endmodule

bind modbus_rtu_response_checker_unit mrrc_checker u_mrrc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_frame_end     (in_ch.frame_end),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_kind  (out_ch.result_kind),
  .out_word_value   (out_ch.word_value),
  .out_word_index   (out_ch.word_index),
  .out_frame_status (out_ch.frame_status)
);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU response checker testbench
// Drives received bytes and idle-line markers into the checker, predicts every
// register word and frame status, and compares them as they come out.
// ----------------------------------------------------------------------------
module testbench;

  // Byte stream of one frame, before the end marker.
  typedef logic [7:0] byte_q_t[$];

  // One result as it leaves the checker.
  typedef struct packed {
    logic              kind;
    logic [15:0]       value;
    logic [6:0]        index;
    mrrc_pkg::status_t status;
  } result_t;

  // The awaited kind that the checker treats like "nothing awaited".
  localparam mrrc_pkg::kind_t KIND_UNUSED = 2'd3;

  localparam int ITEM_TARGET     = 1750;
  localparam int CALM_FROM       = 1500;  // no idling past this many transfers
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT  = 1000;

  // --------------------------------------------------------------------------
  // Frame tracker: follows the checker's frame state byte by byte and keeps
  // the words and statuses that still have to come out, oldest first.
  // --------------------------------------------------------------------------
  class rtu_frame_tracker;
    logic [7:0]      slave_addr;
    mrrc_pkg::kind_t awaited;
    logic [8:0]      position;
    logic [15:0]     crc_acc;
    logic [7:0]      byte_count;
    logic [7:0]      high_hold;
    logic [15:0]     carried_crc;
    logic            addr_bad;
    logic            func_bad;
    result_t         queued_results[$];

    function new();
      slave_addr = mrrc_pkg::ADDR_RESET;
      awaited    = mrrc_pkg::KIND_NONE;
      restart();
    endfunction

    // Bit-serial form of the reflected CRC-16 byte update.
    static function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc;
      for (int k = 0; k < 8; k++) begin
        if (c[0] ^ b[k]) begin
          c = (c >> 1) ^ mrrc_pkg::CRC_POLY;
        end else begin
          c = c >> 1;
        end
      end
      return c;
    endfunction

    function void restart();
      position    = '0;
      crc_acc     = mrrc_pkg::CRC_INIT;
      byte_count  = '0;
      high_hold   = '0;
      carried_crc = '0;
      addr_bad    = 1'b0;
      func_bad    = 1'b0;
    endfunction

    function void set_register(logic idx, logic [7:0] val);
      if (idx == mrrc_pkg::CFG_SLAVE_ADDRESS) begin
        slave_addr = val;
      end else begin
        awaited = mrrc_pkg::kind_t'(val[1:0]);
      end
    endfunction

    function mrrc_pkg::status_t closing_status();
      int need;
      if (awaited != mrrc_pkg::KIND_READ && awaited != mrrc_pkg::KIND_WRITE)
        return mrrc_pkg::ST_NOT_AWAITED;
      if (position == 0) return mrrc_pkg::ST_TOO_SHORT;
      if (addr_bad) return mrrc_pkg::ST_ADDR_MISMATCH;
      if (awaited == mrrc_pkg::KIND_WRITE) begin
        if (position < 2) return mrrc_pkg::ST_TOO_SHORT;
        if (func_bad) return mrrc_pkg::ST_FUNC_MISMATCH;
        need = int'(mrrc_pkg::WRITE_COVER) + 2;
      end else begin
        if (position < 3) return mrrc_pkg::ST_TOO_SHORT;
        need = int'(byte_count) + 5;
      end
      if (int'(position) < need) return mrrc_pkg::ST_TOO_SHORT;
      if (crc_acc != carried_crc) return mrrc_pkg::ST_CRC_MISMATCH;
      return mrrc_pkg::ST_OK;
    endfunction

    // Note one accepted input transfer.
    function void take_transfer(logic [7:0] b, logic frame_end);
      int      pos;
      int      cnt;
      result_t r;
      pos = int'(position);
      cnt = int'(byte_count);
      if (frame_end) begin
        r        = '0;
        r.kind   = mrrc_pkg::RK_STATUS;
        r.status = closing_status();
        queued_results.push_back(r);
        restart();
        return;
      end
      if ((awaited == mrrc_pkg::KIND_READ || awaited == mrrc_pkg::KIND_WRITE)
          && pos == 0 && b != slave_addr) begin
        addr_bad = 1'b1;
      end
      if (awaited == mrrc_pkg::KIND_READ) begin
        if (pos == 2) begin
          byte_count = b;
          cnt        = int'(b);
        end
        if (pos < 3 || pos < cnt + 3) begin
          crc_acc = crc_update(crc_acc, b);
          if (pos >= 3) begin
            if (((pos - 3) % 2) == 0) begin
              high_hold = b;
            end else begin
              r       = '0;
              r.kind  = mrrc_pkg::RK_WORD;
              r.value = {high_hold, b};
              r.index = 7'((pos - 4) / 2);
              queued_results.push_back(r);
            end
          end
        end else if (pos == cnt + 3) begin
          carried_crc[7:0] = b;
        end else if (pos == cnt + 4) begin
          carried_crc[15:8] = b;
        end
      end else if (awaited == mrrc_pkg::KIND_WRITE) begin
        if (pos == 1 && b != mrrc_pkg::WRITE_FUNCTION) func_bad = 1'b1;
        if (pos < int'(mrrc_pkg::WRITE_COVER)) begin
          crc_acc = crc_update(crc_acc, b);
        end else if (pos == int'(mrrc_pkg::WRITE_COVER)) begin
          carried_crc[7:0] = b;
        end else if (pos == int'(mrrc_pkg::WRITE_COVER) + 1) begin
          carried_crc[15:8] = b;
        end
      end
      if (position != mrrc_pkg::POS_MAX) position++;
    endfunction

    // Compare one result with the oldest expectation; empty string if it matches.
    function string match_result(result_t got);
      result_t want;
      string   msg;
      if (queued_results.size() == 0) begin
        return $sformatf(" unexpected result kind=%0d value=%h index=%0d status=%0d",
                         got.kind, got.value, got.index, got.status);
      end
      want = queued_results.pop_front();
      msg  = "";
      if (got.kind !== want.kind)
        msg = {msg, $sformatf(" result_kind %0d, want %0d", got.kind, want.kind)};
      if (got.value !== want.value)
        msg = {msg, $sformatf(" word_value %h, want %h", got.value, want.value)};
      if (got.index !== want.index)
        msg = {msg, $sformatf(" word_index %0d, want %0d", got.index, want.index)};
      if (got.status !== want.status)
        msg = {msg, $sformatf(" frame_status %0d, want %0d", got.status, want.status)};
      return msg;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;

  mrrc_in_if  in_ch();
  mrrc_out_if out_ch();

  modbus_rtu_response_checker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rtu_frame_tracker tracker;
  int   mismatch_count = 0;
  int   items_sent     = 0;
  bit   sender_idles   = 1'b1;
  bit   receiver_stalls = 1'b1;
  bit   hold_off_req   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("ERROR at %0t:%s", $time, what);
  endtask

  // Mostly random bytes, with the extremes now and then.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Append the frame CRC, low byte first; optionally flip one bit of it.
  function automatic byte_q_t append_crc(byte_q_t q, bit corrupt);
    logic [15:0] crc;
    crc = mrrc_pkg::CRC_INIT;
    foreach (q[i]) crc = rtu_frame_tracker::crc_update(crc, q[i]);
    if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    q.push_back(crc[7:0]);
    q.push_back(crc[15:8]);
    return q;
  endfunction

  // Offer one byte or end marker and hold it until the checker takes it.
  // Random idle bursts land in front of the offer when the sender idles.
  task automatic offer_transfer(input logic [7:0] b, input logic frame_end);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.rx_byte   <= b;
    in_ch.frame_end <= frame_end;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.take_transfer(b, frame_end);
    items_sent++;
  endtask

  // Send the bytes of one frame, then the idle-line marker with a junk byte.
  task automatic send_sequence(input byte_q_t frame_bytes);
    foreach (frame_bytes[i]) offer_transfer(frame_bytes[i], 1'b0);
    offer_transfer(pick_byte(), 1'b1);
  endtask

  // Drop valid, wait for every expected result, then let the checker run on for
  // SETTLE_CYCLES in case the last bytes are still working their way through.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.queued_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back once the checker has gone quiet.
  task automatic set_registers(input logic [7:0] addr, input mrrc_pkg::kind_t kind);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= mrrc_pkg::CFG_SLAVE_ADDRESS;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_index <= mrrc_pkg::CFG_EXPECTED_KIND;
    cfg_wdata <= {6'b0, kind};
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_register(mrrc_pkg::CFG_SLAVE_ADDRESS, addr);
    tracker.set_register(mrrc_pkg::CFG_EXPECTED_KIND, {6'b0, kind});
  endtask

  // Build one frame shaped for the awaited kind: mostly well formed, with
  // wrong addresses, wrong function codes, bad CRCs, cut-off frames, trailing
  // bytes and plain noise mixed in. With a count hint, a read-mode frame is clean.
  task automatic send_frame(input mrrc_pkg::kind_t k, input logic [7:0] addr,
                            input int count_hint, input int tail_len);
    byte_q_t fb;
    int      shape;
    int      count;
    int      keep;
    shape = $urandom_range(0, 99);
    fb    = {};
    if (count_hint < 0 && shape < 8) begin
      repeat ($urandom_range(0, 12)) fb.push_back(pick_byte());
    end else begin
      if (k == mrrc_pkg::KIND_READ || (k != mrrc_pkg::KIND_WRITE && shape < 54)) begin
        fb.push_back(($urandom_range(0, 9) == 0 && count_hint < 0) ? pick_byte() : addr);
        fb.push_back(pick_byte());
        if (count_hint >= 0) begin
          count = count_hint;
        end else if ($urandom_range(0, 19) == 0) begin
          count = $urandom_range(0, 255);
        end else begin
          count = $urandom_range(0, 12);
        end
        fb.push_back(8'(count));
        repeat (count) fb.push_back(pick_byte());
      end else begin
        fb.push_back(($urandom_range(0, 9) == 0) ? pick_byte() : addr);
        fb.push_back(($urandom_range(0, 9) == 0) ? pick_byte() : mrrc_pkg::WRITE_FUNCTION);
        repeat (4) fb.push_back(pick_byte());
      end
      fb = append_crc(fb, count_hint < 0 && $urandom_range(0, 11) == 0);
      if (count_hint < 0 && $urandom_range(0, 9) == 0) begin
        keep = $urandom_range(0, fb.size() - 1);
        while (fb.size() > keep) fb.delete(fb.size() - 1);
      end
      if (count_hint < 0 && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) fb.push_back(pick_byte());
      end
    end
    repeat (tail_len) fb.push_back(pick_byte());
    send_sequence(fb);
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready with random stall bursts, plus one long hold-off on
  // request so the result register fills and the input side backs up.
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Check every result transfer against the oldest expectation.
  initial begin
    result_t got;
    string   msg;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.kind   = out_ch.result_kind;
        got.value  = out_ch.word_value;
        got.index  = out_ch.word_index;
        got.status = out_ch.frame_status;
        msg = tracker.match_result(got);
        if (msg != "") flag_mismatch(msg);
      end
    end
  end

  // Watchdog: give up when no transfer happens on either channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    byte_q_t         q;
    logic [7:0]      addr;
    mrrc_pkg::kind_t kind;
    int              pick;
    int              phase;
    tracker = new();

    // Known values on every input from the first instant.
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = mrrc_pkg::CFG_SLAVE_ADDRESS;
    cfg_wdata       = 8'h00;
    in_ch.valid     = 1'b0;
    in_ch.rx_byte   = 8'h00;
    in_ch.frame_end = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- Directed part ----
    // Nothing awaited after reset: a bare end marker closes as not awaited.
    offer_transfer(pick_byte(), 1'b1);

    // The meaningless kind behaves like nothing awaited, bytes and all.
    set_registers(8'h00, KIND_UNUSED);
    q = {8'h5A};
    send_sequence(q);

    // Read mode, empty frame: too short.
    set_registers(8'hFF, mrrc_pkg::KIND_READ);
    q = {};
    send_sequence(q);

    // Read mode, odd count: one word, a lone last data byte, a trailing byte.
    q = {8'hFF, 8'h03, 8'h03, 8'h00, 8'hFF, 8'hFF};
    q = append_crc(q, 1'b0);
    q.push_back(8'h00);
    send_sequence(q);

    // Address mismatch outranks a frame that is also too short.
    q = {8'h01};
    send_sequence(q);

    // Write mode: function mismatch outranks too short.
    set_registers(8'h00, mrrc_pkg::KIND_WRITE);
    q = {8'h00, 8'h03};
    send_sequence(q);

    // Kind switched from write to read in the middle of a frame.
    offer_transfer(8'h00, 1'b0);
    set_registers(8'h00, mrrc_pkg::KIND_READ);
    q = {8'h10, 8'h02};
    send_sequence(q);

    // ---- Random part ----
    // Phase 0 is a read phase that starts with a long hold-off on the result
    // side over a full-size frame, then runs a frame with a tail long enough
    // to saturate the byte position.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        addr = 8'h00;
      end else if (pick < 20) begin
        addr = 8'hFF;
      end else begin
        addr = 8'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (phase == 0 || pick < 45) begin
        kind = mrrc_pkg::KIND_READ;
      end else if (pick < 80) begin
        kind = mrrc_pkg::KIND_WRITE;
      end else if (pick < 92) begin
        kind = mrrc_pkg::KIND_NONE;
      end else begin
        kind = KIND_UNUSED;
      end
      set_registers(addr, kind);

      // Stretches with and without idling; none at all near the end.
      sender_idles    = ($urandom_range(0, 3) != 0) && (items_sent < CALM_FROM);
      receiver_stalls = ($urandom_range(0, 3) != 0) && (items_sent < CALM_FROM);

      if (phase == 0) begin
        hold_off_req = 1'b1;
        send_frame(kind, addr, 255, 0);
        send_frame(kind, addr, 2, 515);
      end
      repeat ($urandom_range(2, 8)) send_frame(kind, addr, -1, 0);
      phase++;
    end

    // ---- Wind down ----
    in_ch.valid <= 1'b0;
    while (tracker.queued_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
